### rtl/core/pfb_pkg.sv
// Package for the page framebuffer blitter: sizes, command and mode codes,
// the controller-to-datapath command struct and the datapath status struct.
// No dependencies.
`timescale 1ns / 1ps
package pfb_pkg;
    localparam int DisplayWidth  = 128;
    localparam int DisplayHeight = 64;
    localparam int BitmapDepth   = 1024;
    localparam int PageCount     = (DisplayHeight + 7) / 8;
    localparam int FrameBytes    = DisplayWidth * PageCount;
    localparam int FrameAw       = 10;
    localparam int BitmapAw      = $clog2(BitmapDepth);

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_PIXEL = 3'd1,
        CMD_LOAD  = 3'd2,
        CMD_BLIT  = 3'd3,
        CMD_READ  = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_WHITE   = 2'd0,
        MODE_BLACK   = 2'd1,
        MODE_INVERSE = 2'd2,
        MODE_NORMAL  = 2'd3
    } t_mode;

    typedef struct packed {
        logic                frame_rd;
        logic [FrameAw-1:0]  frame_rd_addr;
        logic                bitmap_rd;
        logic [BitmapAw-1:0] bitmap_rd_addr;
        logic                bitmap_wr;
        logic [BitmapAw-1:0] bitmap_wr_addr;
        logic [7:0]          bitmap_wr_data;
    } t_dp_cmd;

    typedef struct packed {
        logic [7:0] frame_q;
        logic [7:0] bitmap_q;
    } t_dp_stat;
endpackage

### rtl/core/pfb_datapath.sv
// Datapath of the page framebuffer blitter: frame and bitmap memories with
// registered reads and one frame write port. Depends on pfb_pkg.
`timescale 1ns / 1ps
module pfb_datapath (
    input  logic                         i_clk,
    input  pfb_pkg::t_dp_cmd             i_cmd,
    input  logic                         i_fwr,
    input  logic [pfb_pkg::FrameAw-1:0]  i_fwr_addr,
    input  logic [7:0]                   i_fwr_data,
    output pfb_pkg::t_dp_stat            o_stat
);
    import pfb_pkg::*;

    logic [7:0] r_frame [0:(1<<FrameAw)-1];
    logic [7:0] r_bitmap [0:BitmapDepth-1];
    logic [7:0] r_fq;
    logic [7:0] r_bq;

    always_ff @(posedge i_clk) begin
        if (i_fwr) begin
            r_frame[i_fwr_addr] <= i_fwr_data;
        end
        if (i_cmd.frame_rd) begin
            r_fq <= r_frame[i_cmd.frame_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bitmap_wr) begin
            r_bitmap[i_cmd.bitmap_wr_addr] <= i_cmd.bitmap_wr_data;
        end
        if (i_cmd.bitmap_rd) begin
            r_bq <= r_bitmap[i_cmd.bitmap_rd_addr];
        end
    end

    assign o_stat.frame_q  = r_fq;
    assign o_stat.bitmap_q = r_bq;
endmodule

### rtl/core/pfb_ctrl.sv
// Controller of the page framebuffer blitter: command decode, clearing pass,
// read-modify-write sequencing of pixels and blits. Depends on pfb_pkg.
`timescale 1ns / 1ps
module pfb_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_valid,
    output logic                         o_s_ready,
    input  logic [2:0]                   i_command,
    input  logic signed [7:0]            i_pos_x,
    input  logic signed [7:0]            i_pos_y,
    input  logic [7:0]                   i_width,
    input  logic [7:0]                   i_height,
    input  logic [1:0]                   i_mode,
    input  logic [7:0]                   i_data_byte,
    input  logic [9:0]                   i_address,
    output logic                         o_m_valid,
    input  logic                         i_m_ready,
    output logic [7:0]                   o_read_data,
    output logic                         o_skipped,
    output pfb_pkg::t_dp_cmd             o_cmd,
    output logic                         o_fwr,
    output logic [pfb_pkg::FrameAw-1:0]  o_fwr_addr,
    output logic [7:0]                   o_fwr_data,
    input  pfb_pkg::t_dp_stat            i_stat
);
    import pfb_pkg::*;

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_CLR   = 7'b0000100,
        S_PIXRD = 7'b0001000,
        S_PIXWR = 7'b0010000,
        S_BRD   = 7'b0100000,
        S_BWR   = 7'b1000000
    } t_state;

    localparam int PgW = $clog2(PageCount + 1);
    localparam int ColW = $clog2(DisplayWidth + 1);

    t_state r_state, n_state;
    logic [FrameAw:0] r_ccnt;
    logic [7:0] r_cval;
    logic r_ovalid;
    logic [7:0] r_rdata;
    logic r_skip;
    logic r_rdpend;
    logic [7:0] r_pmask;
    logic [1:0] r_mode;
    logic [FrameAw-1:0] r_addr;
    logic signed [9:0] r_px, r_py;
    logic [7:0] r_w;
    logic [ColW-1:0] r_x, r_x0, r_x1;
    logic [PgW-1:0] r_pg, r_pg1;
    logic [6:0] r_y0, r_y1;
    logic [7:0] r_bq2;
    logic r_lo_ok, r_hi_ok, r_lo_in, r_hi_in;
    logic [BitmapAw:0] r_idx_lo;
    logic [2:0] r_sh;
    logic [1:0] r_bph;

    wire out_free = !r_ovalid || i_m_ready;
    assign o_s_ready = (r_state == S_IDLE) && out_free;
    wire acc = i_s_valid && o_s_ready;

    assign o_m_valid = r_ovalid;
    assign o_read_data = r_rdpend ? i_stat.frame_q : r_rdata;
    assign o_skipped = r_skip;

    // Blit geometry at acceptance.
    logic signed [9:0] a_px, a_py, a_x1, a_y1, a_x0, a_y0;
    always_comb begin
        a_px = 10'(i_pos_x);
        a_py = 10'(i_pos_y);
        a_x0 = a_px < 0 ? 10'sd0 : a_px;
        a_y0 = a_py < 0 ? 10'sd0 : a_py;
        a_x1 = a_px + $signed({2'b0, i_width});
        a_y1 = a_py + $signed({2'b0, i_height});
        if (a_x1 > DisplayWidth) a_x1 = 10'(DisplayWidth);
        if (a_y1 > DisplayHeight) a_y1 = 10'(DisplayHeight);
    end
    wire blit_empty = (a_x0 >= a_x1) || (a_y0 >= a_y1);
    wire pix_off = i_pos_x < 0 || i_pos_y < 0 || 10'(i_pos_x) >= DisplayWidth
                   || 10'(i_pos_y) >= DisplayHeight;

    // Blit byte geometry for the current page and column.
    logic [7:0] g_mask;
    logic signed [9:0] g_rtop;
    logic [9:0] g_ptop;
    logic [FrameAw-1:0] g_faddr;
    always_comb begin
        g_ptop = {3'b000, r_pg, 3'b000};
        g_mask = 8'hFF;
        for (int b = 0; b < 8; b++) begin
            if (g_ptop + 10'(b) < 10'(r_y0) || g_ptop + 10'(b) >= 10'(r_y1))
                g_mask[b] = 1'b0;
        end
        g_rtop = $signed(g_ptop) - r_py;
        g_faddr = FrameAw'(r_pg * DisplayWidth + r_x);
    end

    // Bitmap byte indexes for the two bitmap pages that feed one frame byte.
    logic signed [9:0] g_rlo;
    logic [6:0] g_blo;
    logic [BitmapAw+8:0] g_ilo_w, g_ihi_w;
    logic [7:0] g_c;
    always_comb begin
        g_rlo = g_rtop;
        g_blo = 7'(g_rlo >>> 3);
        g_c = 8'(10'(r_x) - r_px);
        g_ilo_w = (BitmapAw+9)'(g_blo) * r_w + g_c;
        g_ihi_w = (BitmapAw+9)'(7'(g_blo + 7'd1)) * r_w + g_c;
    end

    // Merge of the new bits.
    logic [15:0] m_pair;
    logic [7:0] m_bits, m_new;
    always_comb begin
        m_pair = {(r_hi_ok ? r_bq2 : 8'h00), (r_lo_ok ? i_stat.bitmap_q : 8'h00)};
        m_bits = 8'(m_pair >> r_sh);
        m_new = m_bits;
        case (r_mode)
            MODE_WHITE:   m_new = 8'hFF;
            MODE_BLACK:   m_new = 8'h00;
            MODE_INVERSE: m_new = ~m_bits;
            default:      m_new = m_bits;
        endcase
    end

    // Bitmap read sequencing uses a two-read phase counter in S_BRD.
    always_comb begin
        o_cmd = '0;
        o_fwr = 1'b0;
        o_fwr_addr = r_addr;
        o_fwr_data = 8'h00;
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                o_fwr = 1'b1;
                o_fwr_addr = FrameAw'(r_ccnt);
                o_fwr_data = 8'h00;
                if (r_ccnt == (FrameAw+1)'((1 << FrameAw) - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (acc) begin
                    case (i_command)
                        CMD_CLEAR: if (i_mode == MODE_WHITE || i_mode == MODE_BLACK)
                            n_state = S_CLR;
                        CMD_PIXEL: if (!pix_off && i_mode != MODE_NORMAL)
                            n_state = S_PIXRD;
                        CMD_LOAD: begin
                            o_cmd.bitmap_wr = 1'b1;
                            o_cmd.bitmap_wr_addr = BitmapAw'(i_address);
                            o_cmd.bitmap_wr_data = i_data_byte;
                        end
                        CMD_BLIT: if (!blit_empty) n_state = S_BRD;
                        CMD_READ: begin
                            o_cmd.frame_rd = 1'b1;
                            o_cmd.frame_rd_addr = i_address;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR: begin
                o_fwr = 1'b1;
                o_fwr_addr = FrameAw'(r_ccnt);
                o_fwr_data = r_cval;
                if (r_ccnt == (FrameAw+1)'(FrameBytes - 1)) n_state = S_IDLE;
            end
            S_PIXRD: begin
                o_cmd.frame_rd = 1'b1;
                o_cmd.frame_rd_addr = r_addr;
                n_state = S_PIXWR;
            end
            S_PIXWR: begin
                o_fwr = 1'b1;
                case (r_mode)
                    MODE_WHITE: o_fwr_data = i_stat.frame_q | r_pmask;
                    MODE_BLACK: o_fwr_data = i_stat.frame_q & ~r_pmask;
                    default:    o_fwr_data = i_stat.frame_q ^ r_pmask;
                endcase
                n_state = S_IDLE;
            end
            S_BRD: begin
                case (r_bph)
                    2'd0: begin
                        o_cmd.bitmap_rd = 1'b1;
                        o_cmd.bitmap_rd_addr = BitmapAw'(g_ihi_w);
                    end
                    2'd1: begin
                        o_cmd.bitmap_rd = 1'b1;
                        o_cmd.bitmap_rd_addr = BitmapAw'(r_idx_lo);
                        o_cmd.frame_rd = 1'b1;
                        o_cmd.frame_rd_addr = g_faddr;
                    end
                    default: n_state = S_BWR;
                endcase
            end
            S_BWR: begin
                o_fwr = 1'b1;
                o_fwr_addr = g_faddr;
                o_fwr_data = (i_stat.frame_q & ~g_mask) | (m_new & g_mask);
                if (r_x + 1'b1 == r_x1 && r_pg + 1'b1 == r_pg1) n_state = S_IDLE;
                else n_state = S_BRD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ccnt <= '0;
            r_ovalid <= 1'b0;
            r_rdpend <= 1'b0;
            r_bph <= '0;
        end else begin
            r_state <= n_state;
            if (o_m_valid && i_m_ready) begin
                r_ovalid <= 1'b0;
            end
            if (r_rdpend) begin
                r_rdata <= i_stat.frame_q;
                r_rdpend <= 1'b0;
            end
            if (r_state == S_INIT || r_state == S_CLR) r_ccnt <= r_ccnt + 1'b1;
            if (r_state == S_BRD) begin
                r_bph <= r_bph + 1'b1;
                if (r_bph == 2'd1) r_bq2 <= i_stat.bitmap_q;
            end
            if (r_state == S_BWR) begin
                r_bph <= '0;
                if (r_x + 1'b1 == r_x1) begin
                    r_x <= r_x0;
                    r_pg <= r_pg + 1'b1;
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
            if (acc) begin
                r_ovalid <= 1'b1;
                r_rdata <= 8'h00;
                r_skip <= 1'b0;
                r_mode <= i_mode;
                r_ccnt <= '0;
                r_bph <= '0;
                r_cval <= (i_mode == MODE_WHITE) ? 8'hFF : 8'h00;
                r_addr <= FrameAw'((10'(i_pos_y) >> 3) * DisplayWidth + 10'(i_pos_x));
                r_pmask <= 8'(1) << i_pos_y[2:0];
                r_px <= a_px;
                r_py <= a_py;
                r_w <= i_width;
                r_x0 <= ColW'(a_x0);
                r_x <= ColW'(a_x0);
                r_x1 <= ColW'(a_x1);
                r_y0 <= 7'(a_y0);
                r_y1 <= 7'(a_y1);
                r_pg <= PgW'(a_y0 >>> 3);
                r_pg1 <= PgW'((a_y1 + 10'sd7) >>> 3);
                if (i_command == CMD_PIXEL) r_skip <= pix_off;
                if (i_command == CMD_BLIT) r_skip <= blit_empty;
                if (i_command == CMD_READ) begin
                    r_rdpend <= ({1'b0, i_address} < 11'(FrameBytes));
                end
            end
        end
    end

    // Bitmap index registers for the upcoming byte; shift and range flags.
    logic signed [9:0] g_rbot;
    always_comb g_rbot = g_rtop + 10'sd7;
    always_ff @(posedge i_clk) begin
        if (r_state == S_BRD && r_bph == 2'd0) begin
            // Low part comes from bitmap page of g_rtop, high from the next.
            r_idx_lo <= (BitmapAw+1)'(g_ilo_w);
            r_sh <= 3'(g_rtop);
            r_lo_in <= g_ilo_w < (BitmapAw+9)'(BitmapDepth) && g_rtop >= -10'sd7
                       && g_rtop < 10'sd256;
            r_hi_in <= g_ihi_w < (BitmapAw+9)'(BitmapDepth);
        end
        r_lo_ok <= r_lo_in;
        r_hi_ok <= r_hi_in && (g_rbot >= 10'sd0) && (g_rtop[2:0] != 3'd0);
    end
endmodule

### rtl/core/page_framebuffer_bitmap_blitter.sv
// Top level of the page framebuffer blitter: controller plus datapath.
// Output: one word out per command, valid the cycle after acceptance.
// A clear in white or black mode writes all 1024 frame bytes at 128x64, one
// per cycle through the frame write port; a blit reads two bitmap bytes and
// one frame byte per frame byte written, bound by the single bitmap port.
// Reset (synchronous, active low) starts a pass zeroing all 1024 frame bytes.
`timescale 1ns / 1ps
module page_framebuffer_bitmap_blitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[2:0], pos_x[10:3], pos_y[18:11], width[26:19], height[34:27],
    // mode[36:35], data_byte[44:37], address[54:45], zeros above
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_data[7:0], skipped[8], zeros above
    output logic [15:0] m_axis_tdata
);
    import pfb_pkg::*;

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic               w_fwr;
    logic [FrameAw-1:0] w_fwr_addr;
    logic [7:0]         w_fwr_data;
    logic [7:0]         w_rd;
    logic               w_skip;

    pfb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_axis_tvalid), .o_s_ready(s_axis_tready),
        .i_command(s_axis_tdata[2:0]), .i_pos_x(s_axis_tdata[10:3]),
        .i_pos_y(s_axis_tdata[18:11]), .i_width(s_axis_tdata[26:19]),
        .i_height(s_axis_tdata[34:27]), .i_mode(s_axis_tdata[36:35]),
        .i_data_byte(s_axis_tdata[44:37]), .i_address(s_axis_tdata[54:45]),
        .o_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .o_read_data(w_rd), .o_skipped(w_skip),
        .o_cmd(w_cmd), .o_fwr(w_fwr), .o_fwr_addr(w_fwr_addr),
        .o_fwr_data(w_fwr_data), .i_stat(w_stat)
    );

    pfb_datapath u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_fwr(w_fwr), .i_fwr_addr(w_fwr_addr),
        .i_fwr_data(w_fwr_data), .o_stat(w_stat)
    );

    assign m_axis_tdata = {7'd0, w_skip, w_rd};
endmodule

### rtl/core/pfb_checker.sv
// Port checker for the page framebuffer blitter with its bind statement.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
module pfb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [55:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
        else $error("result padding not zero");
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted word gave no result");
    a_no_skip_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'd0)
        else $error("skipped result carries data");
endmodule

bind page_framebuffer_bitmap_blitter pfb_checker u_pfb_checker (.*);
